/* design/sha256_pkg.sv */
// Package for the SHA-256 byte stream hasher: request codes, FSM state type,
// controller/datapath command and status structs, round constant table.
// No dependencies.
package sha256_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int HASH_WORDS  = 8;
    localparam int ROUNDS      = 64;

    localparam logic       REQ_ABSORB = 1'b0;
    localparam logic       REQ_FINISH = 1'b1;
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMPRESS,
        ST_PAD,
        ST_EMIT
    } sha_state_t;

    // Controller to datapath
    typedef struct packed {
        logic       wr_en;     // write one byte into the block buffer
        logic [7:0] wr_byte;
        logic       add_len;   // advance the bit count by 8
        logic       start;     // begin a block compression
        logic       reinit;    // restore initial hash and counts
        logic       emit_adv;  // advance to the next digest word
    } sha_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       busy;      // compression in progress
        logic [5:0] fill;      // bytes held in the block buffer
        logic [63:0] len_bits; // message length in bits
    } sha_stat_t;

    localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

/* design/sha256_dp.sv */
// SHA-256 datapath: block buffer as sixteen big-endian words, rolling
// 16-word message schedule, one compression round per cycle, hash words.
// Depends on sha256_pkg.
module sha256_dp
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  sha_cmd_t    cmd,
    output sha_stat_t   stat,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index
);

    logic [31:0] blk_reg [16];
    logic [31:0] blk_cur [16];
    logic [31:0] w_reg   [16];
    logic [31:0] h_reg   [HASH_WORDS];
    logic [31:0] v_reg   [HASH_WORDS];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  rnd_reg;
    logic        busy_reg;
    logic        fold_reg;
    logic [2:0]  idx_reg;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] w_new, t1, t2, a, e, s0, s1;

    always_comb begin
        s0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        a     = v_reg[0];
        e     = v_reg[4];
        t1 = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
           + ((e & v_reg[5]) ^ (~e & v_reg[6])) + ROUND_K[rnd_reg] + w_reg[0];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
           + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Buffer with this cycle's byte merged in, so a start on the last
    // byte of a block loads the complete block
    always_comb begin
        blk_cur = blk_reg;
        if (cmd.wr_en) begin
            case (fill_reg[1:0])
                2'd0: blk_cur[fill_reg[5:2]][31:24] = cmd.wr_byte;
                2'd1: blk_cur[fill_reg[5:2]][23:16] = cmd.wr_byte;
                2'd2: blk_cur[fill_reg[5:2]][15:8]  = cmd.wr_byte;
                default: blk_cur[fill_reg[5:2]][7:0] = cmd.wr_byte;
            endcase
        end
    end

    // Block buffer: payload, no reset
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            blk_reg <= blk_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            w_reg <= blk_cur;
            v_reg <= h_reg;
        end else if (busy_reg) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg    <= INIT_HASH;
            fill_reg <= '0;
            len_reg  <= '0;
            rnd_reg  <= '0;
            busy_reg <= 1'b0;
            fold_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            fold_reg <= 1'b0;
            if (cmd.wr_en) fill_reg <= fill_reg + 6'd1;
            if (cmd.add_len) len_reg <= len_reg + 64'd8;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end else if (busy_reg) begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'(ROUNDS - 1)) begin
                    busy_reg <= 1'b0;
                    fold_reg <= 1'b1;
                end
            end
            // fold lands in the cycle after the last round; busy covers it below
            if (fold_reg) begin
                for (int i = 0; i < HASH_WORDS; i++) h_reg[i] <= h_reg[i] + v_reg[i];
            end
            if (cmd.emit_adv) idx_reg <= idx_reg + 3'd1;
            if (cmd.reinit) begin
                h_reg    <= INIT_HASH;
                fill_reg <= '0;
                len_reg  <= '0;
                idx_reg  <= '0;
            end
        end
    end

    assign stat.busy     = busy_reg | fold_reg;
    assign stat.fill     = fill_reg;
    assign stat.len_bits = len_reg;
    assign digest_word   = h_reg[idx_reg];
    assign word_index    = idx_reg;

    as_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> !busy_reg && !fold_reg)
        else $error("compression started while busy");
    as_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> !busy_reg && !fold_reg)
        else $error("buffer written during compression");
    as_fold_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fold_reg |-> $past(busy_reg) && !busy_reg)
        else $error("hash fold without finished rounds");

endmodule

/* design/sha256_ctrl.sv */
// SHA-256 controller: accepts requests, sequences padding bytes, block
// compressions and the eight-beat digest output. Depends on sha256_pkg.
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        req_type,
    input  logic [7:0]  msg_byte,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic [2:0]  word_index,
    input  sha_stat_t   stat,
    output sha_cmd_t    cmd
);

    // Padding phases
    localparam logic [3:0] PAD_MARKER = 4'd0;  // write the 0x80 marker
    localparam logic [3:0] PAD_TAIL   = 4'd1;  // zeros, then length from byte 56
    localparam logic [3:0] PAD_SPILL  = 4'd2;  // zeros to block end, length next block

    sha_state_t state_reg, state_next;
    logic [3:0]  pad_reg, pad_next;
    logic [63:0] len_reg, len_next;
    logic        fin_reg, fin_next;     // compression belongs to padding

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pad_reg   <= PAD_MARKER;
            fin_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            pad_reg   <= pad_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge aclk) len_reg <= len_next;

    always_comb begin
        state_next = state_reg;
        pad_next   = pad_reg;
        len_next   = len_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (req_type == REQ_ABSORB) begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_byte = msg_byte;
                        cmd.add_len = 1'b1;
                        if (stat.fill == 6'd63) begin
                            cmd.start  = 1'b1;
                            fin_next   = 1'b0;
                            state_next = ST_COMPRESS;
                        end
                    end else begin
                        len_next   = stat.len_bits;
                        pad_next   = PAD_MARKER;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.wr_en = 1'b1;
                if (pad_reg == PAD_MARKER) begin
                    cmd.wr_byte = PAD_MARK;
                    // marker past byte 55 leaves no room for the length here
                    pad_next    = (stat.fill >= LEN_POS) ? PAD_SPILL : PAD_TAIL;
                end else if (pad_reg == PAD_TAIL && stat.fill >= LEN_POS) begin
                    cmd.wr_byte = len_reg[63 - 8 * (stat.fill[2:0]) -: 8];
                end else begin
                    cmd.wr_byte = '0;
                end
                if (stat.fill == 6'd63) begin
                    cmd.start  = 1'b1;
                    fin_next   = 1'b1;
                    state_next = ST_COMPRESS;
                end
            end
            ST_COMPRESS: begin
                if (!stat.busy) begin
                    if (!fin_reg) begin
                        state_next = ST_IDLE;
                    end else if (pad_reg == PAD_SPILL) begin
                        // length still due: pad a fresh block
                        pad_next   = PAD_TAIL;
                        state_next = ST_PAD;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.emit_adv = 1'b1;
                    if (word_index == 3'd7) begin
                        cmd.reinit = 1'b1;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    as_emit_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> word_index == 3'd0)
        else $error("digest index not cleared");
    as_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.busy |-> !s_tready)
        else $error("input accepted during compression");
    as_emit_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !stat.busy)
        else $error("digest shown during compression");

endmodule

/* design/sha256_byte_stream_hasher_top.sv */
// SHA-256 byte stream hasher, top level. Absorb bytes are accepted back to back while
// idle; the 64th byte of a block starts a 64-round compression, during which s_tready is low.
// Finish: padding bytes are written (a marker past byte 55 spills the length
// into a second block), one or two compressions follow, then
// eight digest beats, one per cycle while m_tready is high.
// aresetn (synchronous, active low) loads the initial hash and clears counts.
// Depends on sha256_pkg, sha256_ctrl, sha256_dp.
module sha256_byte_stream_hasher_top
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] msg_byte
    input  logic        s_tuser,   // req_type: 0 absorb, 1 finish
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest 0
    output logic        m_tlast    // last_word
);

    sha_cmd_t    cmd;
    sha_stat_t   stat;
    logic [31:0] digest_word;
    logic [2:0]  word_index;

    sha256_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready,
        .req_type(s_tuser), .msg_byte(s_tdata),
        .m_tvalid, .m_tready, .word_index, .stat, .cmd
    );

    sha256_dp u_dp (
        .aclk, .aresetn, .cmd, .stat, .digest_word, .word_index
    );

    // Digest beats come straight from the hash registers, which hold
    // until the beat is taken.
    assign m_tdata = {5'd0, word_index, digest_word};
    assign m_tlast = (word_index == 3'd7);

endmodule
